// ===== hw/rtl/mcpw_pkg.sv =====
package mcpw_pkg;

	localparam int unsigned CHANNELS_DEF    = 32;
	localparam int unsigned MSG_ID_BITS_DEF = 16;

	localparam int unsigned DATA_W    = 32;
	localparam int unsigned MASK_W    = 32;
	localparam int unsigned MOD_W     = 5;
	localparam int unsigned CHAN_W    = 5;
	localparam int unsigned MSG_W     = 16;
	localparam int unsigned TOTAL_W   = 6;
	localparam int unsigned KIND_W    = 2;

	localparam logic [TOTAL_W-1:0] STUCK_TOTAL_MAX = TOTAL_W'(63);

	localparam logic [KIND_W-1:0] KIND_INFO  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_COUNT = 2'd1;
	localparam logic [KIND_W-1:0] KIND_TICK  = 2'd2;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic rd_ch;
		logic scan_rd;
		logic copy_rd;
		logic update;
		logic emit;
	} mcpw_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic any_stuck;
	} mcpw_sts_t;

endpackage

// ===== hw/rtl/mcpw_ctrl.sv =====
module mcpw_ctrl #(
	parameter int unsigned CHANNELS = mcpw_pkg::CHANNELS_DEF,
	localparam int unsigned IW = $clog2(CHANNELS)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [mcpw_pkg::KIND_W-1:0] kind,
	output logic                       busy,
	output mcpw_pkg::mcpw_cmd_t        cmd,
	output logic [IW-1:0]              idx,
	input  mcpw_pkg::mcpw_sts_t        sts
);
	import mcpw_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PROG,
		ST_SCAN,
		ST_FINAL,
		ST_COPY,
		ST_CEND,
		ST_READ,
		ST_DONE
	} state_t;

	localparam logic [IW-1:0] LAST_IDX = IW'(CHANNELS - 1);

	state_t        state_q;
	logic [IW-1:0] idx_q;

	assign busy = (state_q != ST_IDLE);
	assign idx  = idx_q;

	always_comb begin
		cmd         = '0;
		cmd.load    = (state_q == ST_IDLE) && start;
		cmd.rd_ch   = (state_q == ST_READ);
		cmd.scan_rd = (state_q == ST_SCAN);
		cmd.copy_rd = (state_q == ST_COPY);
		cmd.update  = (state_q == ST_PROG);
		cmd.emit    = (state_q == ST_PROG) || (state_q == ST_DONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					if (start) begin
						state_q <= (kind == KIND_TICK) ? ST_SCAN : ST_PROG;
					end
				end
				ST_PROG: begin
					state_q <= ST_IDLE;
				end
				ST_SCAN: begin
					if (idx_q == LAST_IDX) begin
						idx_q   <= '0;
						state_q <= ST_FINAL;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_FINAL: begin
					// last compare lands this cycle; skip the copy once a fault is set
					idx_q   <= '0;
					state_q <= sts.any_stuck ? ST_READ : ST_COPY;
				end
				ST_COPY: begin
					if (idx_q == LAST_IDX) begin
						idx_q   <= '0;
						state_q <= ST_CEND;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_CEND: begin
					state_q <= ST_READ;
				end
				ST_READ: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
					idx_q   <= '0;
				end
			endcase
		end
	end

endmodule

// ===== hw/rtl/mcpw_datapath.sv =====
module mcpw_datapath #(
	parameter int unsigned CHANNELS    = mcpw_pkg::CHANNELS_DEF,
	parameter int unsigned MSG_ID_BITS = mcpw_pkg::MSG_ID_BITS_DEF,
	localparam int unsigned IW = $clog2(CHANNELS)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  mcpw_pkg::mcpw_cmd_t          cmd,
	input  logic [IW-1:0]                idx,
	output mcpw_pkg::mcpw_sts_t          sts,
	input  logic [mcpw_pkg::KIND_W-1:0]  kind,
	input  logic [mcpw_pkg::CHAN_W-1:0]  channel,
	input  logic [mcpw_pkg::MOD_W-1:0]   src_module,
	input  logic [mcpw_pkg::MSG_W-1:0]   msg_id,
	input  logic [mcpw_pkg::MOD_W-1:0]   dst_module,
	input  logic [mcpw_pkg::MASK_W-1:0]  enable_mask,
	output logic                         done,
	output logic [mcpw_pkg::DATA_W-1:0]  channel_total,
	output logic                         stuck_found,
	output logic [mcpw_pkg::CHAN_W-1:0]  first_stuck,
	output logic [mcpw_pkg::TOTAL_W-1:0] stuck_total,
	output logic                         fault_flag,
	output logic [mcpw_pkg::MOD_W-1:0]   stuck_src,
	output logic [mcpw_pkg::MSG_W-1:0]   stuck_msg,
	output logic [mcpw_pkg::MOD_W-1:0]   stuck_dst
);
	import mcpw_pkg::*;

	// message ids are stored no wider than the port carries
	localparam int unsigned MW     = (MSG_ID_BITS < MSG_W) ? MSG_ID_BITS : MSG_W;
	localparam int unsigned INFO_W = 2 * MOD_W + MW;

	logic [DATA_W-1:0] live_mem [CHANNELS];
	logic [DATA_W-1:0] snap_mem [CHANNELS];
	logic [INFO_W-1:0] info_mem [CHANNELS];

	logic [CHANNELS-1:0] live_vld_q;
	logic [CHANNELS-1:0] snap_vld_q;
	logic [CHANNELS-1:0] info_vld_q;

	// latched transaction
	logic [KIND_W-1:0] kind_q;
	logic [IW-1:0]     ch_idx_q;
	logic              ch_ok_q;
	logic [MOD_W-1:0]  src_q;
	logic [MW-1:0]     msg_q;
	logic [MOD_W-1:0]  dst_q;

	// read stage
	logic [IW-1:0]     rd_addr;
	logic [IW-1:0]     addr_s1;
	logic [DATA_W-1:0] live_rd_s1;
	logic [DATA_W-1:0] snap_rd_s1;
	logic [INFO_W-1:0] info_rd_s1;
	logic              lv_s1;
	logic              sv_s1;
	logic              iv_s1;
	logic              scan_v_s1;
	logic              copy_v_s1;

	// scan accumulators
	logic               fault_q;
	logic               found_q;
	logic [IW-1:0]      first_q;
	logic [TOTAL_W-1:0] total_q;
	logic [INFO_W-1:0]  first_info_q;

	// result registers
	logic               done_q;
	logic [DATA_W-1:0]  total_out_q;
	logic               found_out_q;
	logic [CHAN_W-1:0]  first_out_q;
	logic [TOTAL_W-1:0] cnt_out_q;
	logic               fault_out_q;
	logic [INFO_W-1:0]  info_out_q;

	logic [DATA_W-1:0] live_val;
	logic [DATA_W-1:0] snap_val;
	logic [INFO_W-1:0] info_val;
	logic [DATA_W-1:0] sum;
	logic              incr;
	logic              info_wr;
	logic              watched;
	logic              hit;

	always_comb begin
		if (cmd.load) begin
			rd_addr = IW'(channel);
		end else if (cmd.rd_ch) begin
			rd_addr = ch_idx_q;
		end else begin
			rd_addr = idx;
		end
	end

	assign live_val = lv_s1 ? live_rd_s1 : '0;
	assign snap_val = sv_s1 ? snap_rd_s1 : '0;
	assign info_val = iv_s1 ? info_rd_s1 : '0;

	assign incr    = cmd.update && ch_ok_q && ((kind_q == KIND_INFO) || (kind_q == KIND_COUNT));
	assign info_wr = cmd.update && ch_ok_q && (kind_q == KIND_INFO);
	// carry-in folds the increment into the readback add
	assign sum     = DATA_W'(live_val + snap_val + DATA_W'(incr));

	always_comb begin
		if (32'(addr_s1) >= MASK_W) begin
			watched = 1'b1;
		end else begin
			watched = enable_mask[5'(addr_s1)];
		end
	end

	assign hit = scan_v_s1 && watched && live_val[0] && (live_val == snap_val);

	assign sts.any_stuck = fault_q | hit;

	// memories and payload
	always_ff @(posedge clk) begin
		live_rd_s1 <= live_mem[rd_addr];
		snap_rd_s1 <= snap_mem[rd_addr];
		info_rd_s1 <= info_mem[rd_addr];
		lv_s1      <= live_vld_q[rd_addr];
		sv_s1      <= snap_vld_q[rd_addr];
		iv_s1      <= info_vld_q[rd_addr];
		addr_s1    <= rd_addr;

		if (incr) begin
			live_mem[ch_idx_q] <= DATA_W'(live_val + 1'b1);
		end
		if (info_wr) begin
			info_mem[ch_idx_q] <= {src_q, msg_q, dst_q};
		end
		if (copy_v_s1) begin
			snap_mem[addr_s1] <= live_val;
		end

		if (cmd.load) begin
			kind_q   <= kind;
			ch_idx_q <= IW'(channel);
			ch_ok_q  <= (32'(channel) < CHANNELS);
			src_q    <= src_module;
			msg_q    <= msg_id[MW-1:0];
			dst_q    <= dst_module;
		end

		if (cmd.emit) begin
			total_out_q <= ch_ok_q ? sum : '0;
			found_out_q <= found_q;
			first_out_q <= CHAN_W'(first_q);
			cnt_out_q   <= total_q;
			fault_out_q <= fault_q;
			info_out_q  <= first_info_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_vld_q   <= '0;
			snap_vld_q   <= '0;
			info_vld_q   <= '0;
			scan_v_s1    <= 1'b0;
			copy_v_s1    <= 1'b0;
			fault_q      <= 1'b0;
			found_q      <= 1'b0;
			first_q      <= '0;
			total_q      <= '0;
			first_info_q <= '0;
			done_q       <= 1'b0;
		end else begin
			scan_v_s1 <= cmd.scan_rd;
			copy_v_s1 <= cmd.copy_rd;
			done_q    <= cmd.emit;

			if (incr) begin
				live_vld_q[ch_idx_q] <= 1'b1;
			end
			if (info_wr) begin
				info_vld_q[ch_idx_q] <= 1'b1;
			end
			if (copy_v_s1) begin
				snap_vld_q[addr_s1] <= 1'b1;
			end

			if (cmd.load) begin
				found_q      <= 1'b0;
				first_q      <= '0;
				total_q      <= '0;
				first_info_q <= '0;
			end else if (hit) begin
				fault_q <= 1'b1;
				if (!found_q) begin
					found_q      <= 1'b1;
					first_q      <= addr_s1;
					first_info_q <= info_val;
				end
				if (total_q != STUCK_TOTAL_MAX) begin
					total_q <= total_q + 1'b1;
				end
			end
		end
	end

	assign done          = done_q;
	assign channel_total = total_out_q;
	assign stuck_found   = found_out_q;
	assign first_stuck   = first_out_q;
	assign stuck_total   = cnt_out_q;
	assign fault_flag    = fault_out_q;
	assign stuck_src     = info_out_q[INFO_W-1 -: MOD_W];
	assign stuck_msg     = MSG_W'(info_out_q[MOD_W +: MW]);
	assign stuck_dst     = info_out_q[MOD_W-1:0];

endmodule

// ===== hw/rtl/multi_channel_progress_watchdog_core.sv =====
// Multi-channel progress watchdog.
// Command channel: drive kind/channel/message fields with start; the transaction
// is taken on an edge where start is high and busy is low. Progress events
// (kind 0 with message info, kind 1 count only) bump the channel counter; kind 2
// is a check tick that scans every channel for an odd count unchanged since the
// last tick that copied the snapshots.
// Result channel: one result per transaction, valid on the outputs while done is high for
// exactly one cycle; the receiver cannot stall it.
// Timing: a progress event keeps busy high for a single cycle, and a new event is
// taken only after busy drops; done is registered from the PROG state. A tick walks the
// counter memories one entry per cycle through a single read port, then skips the
// snapshot copy sweep when a stuck channel is found or a fault is latched, and
// otherwise runs the copy sweep before the result is read out.
// Configuration: APB, register 0 (byte address 0) is the enable mask.
// Reset clears all counters, snapshots, message info and the sticky fault,
// and sets the mask to all ones; no clearing pass is needed.
module multi_channel_progress_watchdog_core #(
	parameter int unsigned CHANNELS    = mcpw_pkg::CHANNELS_DEF,
	parameter int unsigned MSG_ID_BITS = mcpw_pkg::MSG_ID_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [mcpw_pkg::KIND_W-1:0]  kind,
	input  logic [mcpw_pkg::CHAN_W-1:0]  channel,
	input  logic [mcpw_pkg::MOD_W-1:0]   src_module,
	input  logic [mcpw_pkg::MSG_W-1:0]   msg_id,
	input  logic [mcpw_pkg::MOD_W-1:0]   dst_module,
	output logic                         done,
	output logic [mcpw_pkg::DATA_W-1:0]  channel_total,
	output logic                         stuck_found,
	output logic [mcpw_pkg::CHAN_W-1:0]  first_stuck,
	output logic [mcpw_pkg::TOTAL_W-1:0] stuck_total,
	output logic                         fault_flag,
	output logic [mcpw_pkg::MOD_W-1:0]   stuck_src,
	output logic [mcpw_pkg::MSG_W-1:0]   stuck_msg,
	output logic [mcpw_pkg::MOD_W-1:0]   stuck_dst,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [2:0]                   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import mcpw_pkg::*;

	localparam int unsigned IW = $clog2(CHANNELS);

	logic [MASK_W-1:0] mask_q;
	logic              mask_sel;
	mcpw_cmd_t         cmd;
	mcpw_sts_t         sts;
	logic [IW-1:0]     idx;

	// only one register: bit 2 set addresses past it
	assign mask_sel = !paddr[2];
	assign pready   = 1'b1;
	assign prdata   = mask_sel ? mask_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '1;
		end else if (psel && penable && pwrite && mask_sel) begin
			mask_q <= pwdata;
		end
	end

	mcpw_ctrl #(
		.CHANNELS(CHANNELS)
	) u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.kind  (kind),
		.busy  (busy),
		.cmd   (cmd),
		.idx   (idx),
		.sts   (sts)
	);

	mcpw_datapath #(
		.CHANNELS   (CHANNELS),
		.MSG_ID_BITS(MSG_ID_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.idx          (idx),
		.sts          (sts),
		.kind         (kind),
		.channel      (channel),
		.src_module   (src_module),
		.msg_id       (msg_id),
		.dst_module   (dst_module),
		.enable_mask  (mask_q),
		.done         (done),
		.channel_total(channel_total),
		.stuck_found  (stuck_found),
		.first_stuck  (first_stuck),
		.stuck_total  (stuck_total),
		.fault_flag   (fault_flag),
		.stuck_src    (stuck_src),
		.stuck_msg    (stuck_msg),
		.stuck_dst    (stuck_dst)
	);

endmodule
